>>> hw/rtl/per_cpu_trace_ring_buffer_defines.svh
// Assertion macros for the per-CPU trace ring checker.
// Depends on nothing; the including module provides clock and reset.
`ifndef PER_CPU_TRACE_RING_BUFFER_DEFINES_SVH
`define PER_CPU_TRACE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define PTRB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PTRB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that also holds through reset.
`define PTRB_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ptrb_pkg.sv
// Shared constants, codes and the ring entry type of the per-CPU trace ring.
// No dependencies; imported by the top level, the checker and the bench.
package ptrb_pkg;

   localparam int NUM_CPUS   = 4;
   localparam int RING_DEPTH = 256;

   localparam int CPU_IDX_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int RAM_DEPTH  = NUM_CPUS * RING_DEPTH;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);
   localparam int SHOWN_W    = ($clog2(RING_DEPTH + 1) > 9) ? $clog2(RING_DEPTH + 1) : 9;

   localparam int HEAD_W     = 32;
   localparam int ADDR_W     = 64;
   localparam int WANT_W     = 9;
   localparam int POS_W      = 8;
   localparam int CPU_W      = 8;

   localparam int REQ_TDATA_W = 224;
   localparam int RSP_TDATA_W = 272;

   // result tdata bit positions
   localparam int RSP_ACCEPTED_BIT = 0;
   localparam int RSP_TOTAL_LSB    = 1;
   localparam int RSP_DROPPED_LSB  = 33;
   localparam int RSP_SHOWN_LSB    = 65;
   localparam int RSP_VALID_BIT    = 74;

   localparam logic [1:0] MODE_RECORD = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic REG_CAPTURE_ENABLE = 1'b0;
   localparam logic REG_CAPTURE_HOLD   = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] func;
      logic [ADDR_W-1:0] caller;
      logic [ADDR_W-1:0] stamp;
   } ring_entry_type;

endpackage

>>> hw/rtl/per_cpu_trace_ring_buffer.sv
// Top level of the per-CPU overwriting trace ring: head counters, CSRs, pipeline.
// Depends on ptrb_pkg and ptrb_ram.
//
//  channel  | direction | handshake            | carries
//  ---------+-----------+----------------------+-----------------------------------
//  req_     | in        | tvalid/tready        | mode in tuser, record/query fields
//  rsp_     | out       | tvalid/tready        | one result item per request item
//  csr_     | in        | APB, pready always 1 | capture_enable (0x0), hold (0x4)
//
// Cycles: one item per cycle sustained while no result stalls; a taken item loads the
//   ring RAM read and the count stage, then moves on to the result register, from
//   which its result is offered.
// Reset: head counters and write slots clear at once; the ring RAM is not cleared.
// Stalls: a stalled result holds the read stage, which then holds off new items.
module per_cpu_trace_ring_buffer
   import ptrb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, low bit up: cpu_id[7:0], event_kind[8], function_address[72:9],
   //   caller_address[136:73], time_stamp[200:137], want_count[209:201],
   //   entry_position[217:210], zero fill[223:218]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser, low bit up: mode[1:0]
   input  logic [1:0]             req_tuser,
   // rsp_tdata, low bit up: accepted[0], total_events[32:1], dropped_events[64:33],
   //   shown_count[73:65], entry_valid[74], entry_kind[75], entry_function[139:76],
   //   entry_caller[203:140], entry_time[267:204], zero fill[271:268]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   // ---------------------------------------------------------------- fields
   logic [1:0]        req_mode;
   logic [CPU_W-1:0]  req_cpu_id;
   logic              req_event_kind;
   logic [ADDR_W-1:0] req_function_address;
   logic [ADDR_W-1:0] req_caller_address;
   logic [ADDR_W-1:0] req_time_stamp;
   logic [WANT_W-1:0] req_want_count;
   logic [POS_W-1:0]  req_entry_position;

   assign req_mode             = req_tuser;
   assign req_cpu_id           = req_tdata[7:0];
   assign req_event_kind       = req_tdata[8];
   assign req_function_address = req_tdata[72:9];
   assign req_caller_address   = req_tdata[136:73];
   assign req_time_stamp       = req_tdata[200:137];
   assign req_want_count       = req_tdata[209:201];
   assign req_entry_position   = req_tdata[217:210];

   // ---------------------------------------------------------------- CSRs
   logic capture_enable_ff, capture_enable_in;
   logic capture_hold_ff, capture_hold_in;
   logic csr_write;
   logic csr_reg_sel;

   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // Registers sit 4 bytes apart; bit 2 picks one, the low bits are ignored.
   assign csr_reg_sel = csr_paddr[2];

   always_comb begin
      capture_enable_in = capture_enable_ff;
      capture_hold_in   = capture_hold_ff;
      if (csr_write) begin
         if (csr_reg_sel == REG_CAPTURE_ENABLE) begin
            capture_enable_in = csr_pwdata[0];
         end else begin
            capture_hold_in = csr_pwdata[0];
         end
      end
   end

   assign csr_prdata = (csr_reg_sel == REG_CAPTURE_ENABLE) ? {31'b0, capture_enable_ff}
                                                           : {31'b0, capture_hold_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_enable_ff <= 1'b1;
         capture_hold_ff   <= 1'b0;
      end else begin
         capture_enable_ff <= capture_enable_in;
         capture_hold_ff   <= capture_hold_in;
      end
   end

   // ---------------------------------------------------------------- stage 0
   // Each CPU keeps its 32-bit head and, beside it, the head modulo the ring
   // depth, so no divider is needed to find the write slot.
   logic [HEAD_W-1:0] head_ff [NUM_CPUS];
   logic [HEAD_W-1:0] head_in [NUM_CPUS];
   logic [SLOT_W-1:0] slot_ff [NUM_CPUS];
   logic [SLOT_W-1:0] slot_in [NUM_CPUS];

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_advance;
   logic                  req_accept;
   logic [CPU_IDX_W-1:0]  cpu_idx;
   logic                  cpu_ok;
   logic [HEAD_W-1:0]     head_sel;
   logic [SLOT_W-1:0]     slot_sel;
   logic [SHOWN_W-1:0]    shown_base;
   logic [SHOWN_W-1:0]    want_ext;
   logic [SHOWN_W-1:0]    shown;
   logic                  entry_ok;
   logic                  record_ok;
   logic [SHOWN_W:0]      rd_diff;
   logic [SHOWN_W:0]      rd_wrap;
   logic [SLOT_W-1:0]     rd_slot;
   logic [RAM_ADDR_W-1:0] cpu_base;
   logic [RAM_ADDR_W-1:0] wr_addr;
   logic [RAM_ADDR_W-1:0] rd_addr;
   ring_entry_type        wr_entry;
   ring_entry_type        rd_entry;

   assign req_tready = ~s1_valid_ff | s1_advance;
   assign req_accept = req_tvalid & req_tready;

   assign cpu_idx  = req_cpu_id[CPU_IDX_W-1:0];
   assign cpu_ok   = (req_cpu_id < CPU_W'(NUM_CPUS));
   assign head_sel = head_ff[cpu_idx];
   assign slot_sel = slot_ff[cpu_idx];

   // shown = min(total, depth), then limited by a nonzero smaller want
   assign shown_base = (head_sel >= HEAD_W'(RING_DEPTH)) ? SHOWN_W'(RING_DEPTH)
                                                         : head_sel[SHOWN_W-1:0];
   assign want_ext   = SHOWN_W'(req_want_count);
   assign shown      = ((req_want_count != '0) && (want_ext < shown_base)) ? want_ext
                                                                           : shown_base;

   assign entry_ok  = (req_mode == MODE_READ) & cpu_ok &
                      (SHOWN_W'(req_entry_position) < shown);
   assign record_ok = req_accept & (req_mode == MODE_RECORD) & capture_enable_ff &
                      ~capture_hold_ff & cpu_ok;

   // Oldest-first slot: (slot - shown + position) mod depth; for a valid
   // position the difference lies at or above minus one depth, so one wrap suffices.
   assign rd_diff = (SHOWN_W+1)'(slot_sel) + (SHOWN_W+1)'(req_entry_position)
                    - {1'b0, shown};
   assign rd_wrap = rd_diff[SHOWN_W] ? rd_diff + (SHOWN_W+1)'(RING_DEPTH) : rd_diff;
   assign rd_slot = rd_wrap[SLOT_W-1:0];

   assign cpu_base = RAM_ADDR_W'(cpu_idx) * RAM_ADDR_W'(RING_DEPTH);
   assign wr_addr  = cpu_base + RAM_ADDR_W'(slot_sel);
   assign rd_addr  = cpu_base + RAM_ADDR_W'(rd_slot);

   assign wr_entry.kind   = req_event_kind;
   assign wr_entry.func   = req_function_address;
   assign wr_entry.caller = req_caller_address;
   assign wr_entry.stamp  = req_time_stamp;

   // A read is always taken at a later edge than any write it depends on, since
   // only one item is taken per cycle, so the RAM needs no bypass.
   ptrb_ram #(
      .WIDTH ($bits(ring_entry_type)),
      .DEPTH (RAM_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (record_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      for (int c = 0; c < NUM_CPUS; c++) begin
         head_in[c] = head_ff[c];
         slot_in[c] = slot_ff[c];
      end
      if (req_accept && (req_mode == MODE_CLEAR)) begin
         // drop all heads; ring contents stay
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_in[c] = '0;
            slot_in[c] = '0;
         end
      end else if (record_ok) begin
         head_in[cpu_idx] = head_sel + 1'b1;
         slot_in[cpu_idx] = (slot_sel == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_sel + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_ff[c] <= '0;
            slot_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_ff[c] <= head_in[c];
            slot_ff[c] <= slot_in[c];
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Hold the item's counts while the RAM read completes.
   logic               s1_accepted_ff;
   logic               s1_report_ff;
   logic               s1_entry_ok_ff;
   logic [HEAD_W-1:0]  s1_total_ff;
   logic [SHOWN_W-1:0] s1_shown_ff;

   logic rsp_valid_ff, rsp_valid_in;

   assign s1_advance  = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_accepted_ff <= record_ok;
         s1_report_ff   <= cpu_ok & ((req_mode == MODE_QUERY) | (req_mode == MODE_READ));
         s1_entry_ok_ff <= entry_ok;
         s1_total_ff    <= head_sel;
         s1_shown_ff    <= shown;
      end
   end

   // ---------------------------------------------------------------- result
   logic              rsp_accepted_ff;
   logic [HEAD_W-1:0] rsp_total_ff;
   logic [HEAD_W-1:0] rsp_dropped_ff;
   logic [8:0]        rsp_shown_ff;
   logic              rsp_entry_valid_ff;
   logic              rsp_entry_kind_ff;
   logic [ADDR_W-1:0] rsp_entry_function_ff;
   logic [ADDR_W-1:0] rsp_entry_caller_ff;
   logic [ADDR_W-1:0] rsp_entry_time_ff;
   logic [HEAD_W-1:0] dropped;

   assign dropped = (s1_report_ff && (s1_total_ff > HEAD_W'(RING_DEPTH)))
                    ? s1_total_ff - HEAD_W'(RING_DEPTH) : '0;

   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_accepted_ff       <= s1_accepted_ff;
         rsp_total_ff          <= s1_report_ff ? s1_total_ff : '0;
         rsp_dropped_ff        <= dropped;
         rsp_shown_ff          <= s1_report_ff ? s1_shown_ff[8:0] : '0;
         rsp_entry_valid_ff    <= s1_entry_ok_ff;
         rsp_entry_kind_ff     <= s1_entry_ok_ff & rd_entry.kind;
         rsp_entry_function_ff <= s1_entry_ok_ff ? rd_entry.func : '0;
         rsp_entry_caller_ff   <= s1_entry_ok_ff ? rd_entry.caller : '0;
         rsp_entry_time_ff     <= s1_entry_ok_ff ? rd_entry.stamp : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_entry_time_ff, rsp_entry_caller_ff, rsp_entry_function_ff,
                        rsp_entry_kind_ff, rsp_entry_valid_ff, rsp_shown_ff,
                        rsp_dropped_ff, rsp_total_ff, rsp_accepted_ff};

endmodule

>>> hw/rtl/ptrb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module ptrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ptrb_checker.sv
// Port-level checker for the per-CPU trace ring, bound to the top level.
// Depends on ptrb_pkg and per_cpu_trace_ring_buffer_defines.svh.
`include "per_cpu_trace_ring_buffer_defines.svh"

module ptrb_checker
   import ptrb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [HEAD_W-1:0] chk_total;
   logic [HEAD_W-1:0] chk_dropped;

   assign chk_total   = rsp_tdata[RSP_TOTAL_LSB +: HEAD_W];
   assign chk_dropped = rsp_tdata[RSP_DROPPED_LSB +: HEAD_W];

   // a stalled result item holds
   `PTRB_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // nothing waits on the result side just after reset
   `PTRB_ASSERT_RST(a_reset_empty, $past(reset), !rsp_tvalid, "result valid right after reset")

   // a record result never carries a ring entry
   `PTRB_ASSERT_IMP(a_mode_exclusive, rsp_tvalid, !(rsp_tdata[RSP_ACCEPTED_BIT] && rsp_tdata[RSP_VALID_BIT]), "record and read result mixed")

   // a drop count only stands beside a nonzero total above it
   `PTRB_ASSERT_IMP(a_dropped_total, rsp_tvalid && (chk_dropped != '0), chk_total > chk_dropped, "dropped count without total")

endmodule

bind per_cpu_trace_ring_buffer ptrb_checker u_ptrb_checker (.*);

>>> bench/per_cpu_trace_ring_buffer_test.sv
// Self-checking bench for the per-CPU trace ring: directed table, then randomised phases.
// Needs ptrb_pkg and per_cpu_trace_ring_buffer; predicts every result item itself.
`timescale 1ns / 100ps

module per_cpu_trace_ring_buffer_test;
   import ptrb_pkg::*;

   localparam int QUIET_LIMIT = 1000;  // cycles with no handshake at all before giving up
   localparam int TAIL_CYCLES = 8;     // result register plus RAM read, with margin

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  cpu;
      logic        kind;
      logic [63:0] func;
      logic [63:0] caller;
      logic [63:0] stamp;
      logic [8:0]  want;
      logic [7:0]  pos;
   } trace_item_type;

   typedef struct packed {
      logic        accepted;
      logic [31:0] total;
      logic [31:0] dropped;
      logic [8:0]  shown;
      logic        valid;
      logic        kind;
      logic [63:0] func;
      logic [63:0] caller;
      logic [63:0] stamp;
   } trace_result_type;

   // How a directed row is checked: by the predictor, or against a result typed in here; or it is a register write.
   typedef enum logic [1:0] {ROW_PREDICT, ROW_ZERO, ROW_STORED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type   check;
      logic           reg_index;
      logic           reg_value;
      trace_item_type item;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [2:0]             csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // Predictor state: own copy of the head counters, the rings and the two registers.
   logic [31:0]    head_count [NUM_CPUS] = '{default: '0};
   ring_entry_type ring_copy [RAM_DEPTH];
   logic           capture_on = 1'b1;
   logic           capture_held = 1'b0;

   trace_result_type responses_due [$];
   row_kind_type     offer_check = ROW_PREDICT;  // how the item now on the bus is checked
   bit               mismatch_seen = 1'b0;
   int               quiet_cycles = 0;
   int               send_gap_pct = 0;
   int               stall_pct = 0;
   int               stretch_left = 0;

   per_cpu_trace_ring_buffer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Work out the result of one item and advance the ring state as the block would.
   function automatic trace_result_type ring_response(input trace_item_type it);
      trace_result_type      r;
      logic [RAM_ADDR_W-1:0] slot;
      logic [CPU_IDX_W-1:0]  cpu_i;
      logic [31:0]           total;
      logic [31:0]           shown;
      logic [31:0]           window_slot;
      r = '0;
      cpu_i = it.cpu[CPU_IDX_W-1:0];
      if (it.mode == MODE_RECORD) begin
         if (capture_on && !capture_held && it.cpu < NUM_CPUS) begin
            slot = RAM_ADDR_W'(it.cpu * RING_DEPTH + head_count[cpu_i] % RING_DEPTH);
            ring_copy[slot].kind   = it.kind;
            ring_copy[slot].func   = it.func;
            ring_copy[slot].caller = it.caller;
            ring_copy[slot].stamp  = it.stamp;
            head_count[cpu_i] = head_count[cpu_i] + 1;
            r.accepted = 1'b1;
         end
      end else if (it.mode == MODE_CLEAR) begin
         // Zero the heads only; ring contents stay behind, out of every window.
         foreach (head_count[i]) head_count[i] = '0;
      end else if (it.cpu < NUM_CPUS) begin
         total = head_count[cpu_i];
         shown = (total > RING_DEPTH) ? RING_DEPTH : total;
         if (it.want != 0 && it.want < shown) shown = 32'(it.want);
         r.total   = total;
         r.dropped = (total > RING_DEPTH) ? total - RING_DEPTH : '0;
         r.shown   = shown[8:0];
         if (it.mode == MODE_READ && it.pos < shown) begin
            // Window runs oldest first and ends just below the head.
            window_slot = total - shown + it.pos;
            slot = RAM_ADDR_W'(it.cpu * RING_DEPTH + window_slot % RING_DEPTH);
            r.valid  = 1'b1;
            r.kind   = ring_copy[slot].kind;
            r.func   = ring_copy[slot].func;
            r.caller = ring_copy[slot].caller;
            r.stamp  = ring_copy[slot].stamp;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] expected_v,
                              input logic [63:0] actual_v);
      if (expected_v !== actual_v) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, expected_v, actual_v);
         mismatch_seen = 1'b1;
      end
   endtask

   // Watch both channels at the rising edge: predict on every item taken, check every
   // result item against the oldest prediction, and keep the quiet-cycle count.
   always @(posedge clock) begin : monitor
      trace_item_type   seen;
      trace_result_type due;
      if (!reset && req_tvalid && req_tready) begin
         seen.mode   = req_tuser;
         seen.cpu    = req_tdata[7:0];
         seen.kind   = req_tdata[8];
         seen.func   = req_tdata[72:9];
         seen.caller = req_tdata[136:73];
         seen.stamp  = req_tdata[200:137];
         seen.want   = req_tdata[209:201];
         seen.pos    = req_tdata[217:210];
         due = ring_response(seen);
         // Typed-in rows override the prediction; the predictor state still advances.
         if (offer_check == ROW_ZERO) begin
            due = '0;
         end else if (offer_check == ROW_STORED) begin
            due = '0;
            due.accepted = 1'b1;
         end
         responses_due.push_back(due);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (responses_due.size() == 0) begin
            $display("%0t ns: result item with none expected, got %h", $time, rsp_tdata);
            mismatch_seen = 1'b1;
         end else begin
            due = responses_due.pop_front();
            check_field("accepted", 64'(due.accepted), 64'(rsp_tdata[RSP_ACCEPTED_BIT]));
            check_field("total_events", 64'(due.total), 64'(rsp_tdata[RSP_TOTAL_LSB +: 32]));
            check_field("dropped_events", 64'(due.dropped),
                        64'(rsp_tdata[RSP_DROPPED_LSB +: 32]));
            check_field("shown_count", 64'(due.shown), 64'(rsp_tdata[RSP_SHOWN_LSB +: 9]));
            check_field("entry_valid", 64'(due.valid), 64'(rsp_tdata[RSP_VALID_BIT]));
            check_field("entry_kind", 64'(due.kind), 64'(rsp_tdata[75]));
            check_field("entry_function", due.func, rsp_tdata[139:76]);
            check_field("entry_caller", due.caller, rsp_tdata[203:140]);
            check_field("entry_time", due.stamp, rsp_tdata[267:204]);
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
   end

   // Result side: a long hold-off when asked for, otherwise stall at the phase's rate.
   initial begin : result_sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left > 0) begin
            rsp_tready <= 1'b0;
            stretch_left = stretch_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Called at a falling edge; returns at a falling edge once the item is taken,
   // leaving tvalid high so that back-to-back items need no second assignment.
   task automatic offer(input trace_item_type it, input row_kind_type check);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      offer_check = check;
      req_tvalid  <= 1'b1;
      req_tuser   <= it.mode;
      req_tdata   <= {{(REQ_TDATA_W - 218){1'b0}}, it.pos, it.want, it.stamp, it.caller,
                      it.func, it.kind, it.cpu};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop tvalid and hold until every result item has come back.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (responses_due.size() != 0) @(negedge clock);
   endtask

   // Setup cycle, access cycle, then an idle cycle so calls can follow each other.
   task automatic write_register(input logic index, input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {31'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (index == REG_CAPTURE_ENABLE)
         capture_on = value;
      else
         capture_held = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic directed_row_type item_row(input row_kind_type check,
                                                 input logic [1:0] mode,
                                                 input logic [7:0] cpu, input logic kind,
                                                 input logic [63:0] func,
                                                 input logic [63:0] caller,
                                                 input logic [63:0] stamp,
                                                 input logic [8:0] want,
                                                 input logic [7:0] pos);
      directed_row_type row;
      row = '0;
      row.check = check;
      row.item  = '{mode, cpu, kind, func, caller, stamp, want, pos};
      return row;
   endfunction

   function automatic directed_row_type csr_row(input logic index, input logic value);
      directed_row_type row;
      row = '0;
      row.check     = ROW_CSR;
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   // Random item: records lean on CPU 0 so its ring wraps and drops events;
   // the other fields carry noise even where the mode ignores them.
   function automatic trace_item_type random_item(input int record_pct, input int clear_pct);
      trace_item_type it;
      int unsigned    roll;
      roll = $urandom_range(0, 99);
      if (roll < clear_pct)
         it.mode = MODE_CLEAR;
      else if (roll < clear_pct + record_pct)
         it.mode = MODE_RECORD;
      else if (roll < clear_pct + record_pct + (100 - clear_pct - record_pct) / 3)
         it.mode = MODE_QUERY;
      else
         it.mode = MODE_READ;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         it.cpu = 8'd0;
      else if (roll < 93)
         it.cpu = 8'($urandom_range(1, NUM_CPUS - 1));
      else
         it.cpu = 8'($urandom_range(0, 255));
      it.kind   = 1'($urandom_range(0, 1));
      it.func   = {$urandom, $urandom};
      it.caller = {$urandom, $urandom};
      it.stamp  = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 25)
         it.want = 9'd0;
      else if (roll < 35)
         it.want = 9'd256;
      else if (roll < 42)
         it.want = 9'($urandom_range(257, 511));
      else if (roll < 50)
         it.want = 9'd1;
      else
         it.want = 9'($urandom_range(2, 255));
      roll = $urandom_range(0, 99);
      if (roll < 35)
         it.pos = 8'($urandom_range(0, 7));
      else if (roll < 45)
         it.pos = 8'd255;
      else
         it.pos = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // One phase: registers written while idle, then a run of random items.
   task automatic run_phase(input int count, input int gap, input int stall,
                            input int record_pct, input int clear_pct,
                            input logic enable, input logic hold, input int hold_off);
      wait_results_drained();
      write_register(REG_CAPTURE_ENABLE, enable);
      write_register(REG_CAPTURE_HOLD, hold);
      send_gap_pct = gap;
      stall_pct    = stall;
      stretch_left = hold_off;
      repeat (count) offer(random_item(record_pct, clear_pct), ROW_PREDICT);
   endtask

   initial begin : stimulus
      directed_row_type plan [$];
      logic [63:0]      ones;
      ones        = '1;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_RECORD;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // Empty rings: every count is zero and every read misses.
      plan.push_back(item_row(ROW_ZERO, MODE_QUERY, 8'd0, 1'b0, '0, '0, '0, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_ZERO, MODE_READ, 8'd0, 1'b0, '0, '0, '0, 9'd0, 8'd0));
      // Extreme payloads on CPU 0, then read them back through windows of every size.
      plan.push_back(item_row(ROW_STORED, MODE_RECORD, 8'd0, 1'b0, ones, '0, ones, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_STORED, MODE_RECORD, 8'd0, 1'b1, '0, ones, '0, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_PREDICT, MODE_READ, 8'd0, 1'b0, '0, '0, '0, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_PREDICT, MODE_READ, 8'd0, 1'b0, '0, '0, '0, 9'd1, 8'd0));
      plan.push_back(item_row(ROW_PREDICT, MODE_READ, 8'd0, 1'b0, '0, '0, '0, 9'd256, 8'd1));
      plan.push_back(item_row(ROW_PREDICT, MODE_READ, 8'd0, 1'b0, '0, '0, '0, 9'd0, 8'd255));
      plan.push_back(item_row(ROW_STORED, MODE_RECORD, 8'd3, 1'b1, 64'haaaa_aaaa_aaaa_aaaa,
                              64'h5555_5555_5555_5555, 64'h0123_4567_89ab_cdef, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_PREDICT, MODE_QUERY, 8'd3, 1'b0, '0, '0, '0, 9'd511, 8'd0));
      // CPU ids out of range: records ignored, queries and reads all zero.
      plan.push_back(item_row(ROW_ZERO, MODE_RECORD, 8'd4, 1'b0, ones, ones, ones, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_ZERO, MODE_RECORD, 8'd255, 1'b1, ones, ones, ones, 9'd511,
                              8'd255));
      plan.push_back(item_row(ROW_ZERO, MODE_QUERY, 8'd255, 1'b0, '0, '0, '0, 9'd256, 8'd0));
      plan.push_back(item_row(ROW_ZERO, MODE_READ, 8'd4, 1'b0, '0, '0, '0, 9'd511, 8'd255));
      // Capture off, then capture held: records are dropped.
      plan.push_back(csr_row(REG_CAPTURE_ENABLE, 1'b0));
      plan.push_back(item_row(ROW_ZERO, MODE_RECORD, 8'd1, 1'b0, ones, ones, ones, 9'd0, 8'd0));
      plan.push_back(csr_row(REG_CAPTURE_ENABLE, 1'b1));
      plan.push_back(csr_row(REG_CAPTURE_HOLD, 1'b1));
      plan.push_back(item_row(ROW_ZERO, MODE_RECORD, 8'd2, 1'b0, ones, ones, ones, 9'd0, 8'd0));
      plan.push_back(csr_row(REG_CAPTURE_HOLD, 1'b0));
      plan.push_back(item_row(ROW_STORED, MODE_RECORD, 8'd2, 1'b1, 64'h1, 64'h2, 64'h3, 9'd0,
                              8'd0));
      plan.push_back(item_row(ROW_PREDICT, MODE_READ, 8'd2, 1'b0, '0, '0, '0, 9'd0, 8'd0));
      // Clear every head: windows empty again, then restart CPU 0 from slot zero.
      plan.push_back(item_row(ROW_ZERO, MODE_CLEAR, 8'd255, 1'b1, ones, ones, ones, 9'd511,
                              8'd255));
      plan.push_back(item_row(ROW_ZERO, MODE_QUERY, 8'd0, 1'b0, '0, '0, '0, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_ZERO, MODE_READ, 8'd2, 1'b0, '0, '0, '0, 9'd0, 8'd0));
      plan.push_back(item_row(ROW_STORED, MODE_RECORD, 8'd0, 1'b0, 64'h10, 64'h20, 64'h30,
                              9'd0, 8'd0));
      plan.push_back(item_row(ROW_PREDICT, MODE_READ, 8'd0, 1'b0, '0, '0, '0, 9'd0, 8'd0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].check == ROW_CSR) begin
            wait_results_drained();
            write_register(plan[i].reg_index, plan[i].reg_value);
         end else begin
            offer(plan[i].item, plan[i].check);
         end
      end

      // Fill phase first: mostly records with no clears, so CPU 0 gathers many events.
      // It opens with a long result hold-off while items keep coming, to back the block up.
      run_phase(200, 0, 0, 90, 0, 1'b1, 1'b0, 80);
      run_phase(150, 78, 0, 70, 0, 1'b1, 1'b0, 0);
      run_phase(150, 0, 78, 70, 0, 1'b1, 1'b0, 0);
      run_phase(40, 27, 27, 70, 0, 1'b0, 1'b0, 0);
      run_phase(30, 27, 27, 70, 0, 1'b1, 1'b1, 0);
      run_phase(30, 27, 27, 70, 0, 1'b0, 1'b1, 0);
      run_phase(60, 27, 27, 60, 5, 1'b1, 1'b0, 0);

      wait_results_drained();
      // Let any stray result item show up before the verdict.
      repeat (TAIL_CYCLES) @(negedge clock);
      if (!mismatch_seen)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
